// ===== hdl/htr_pkg.sv =====
// ----------------------------------------------------------------------------
// htr_pkg: shared types and constants for the hall tachometer
// Holds the controller state encoding, register map and arithmetic constants.
// ----------------------------------------------------------------------------
package htr_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned RPM_W    = 16;
  localparam int unsigned PROD_W   = RPM_W + COUNT_W;

  // apb register map
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_ARM_THRESHOLD   = 1'b0;
  localparam logic        REG_REVS_PER_UPDATE = 1'b1;

  // register reset values
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 10'd430;
  localparam logic [COUNT_W-1:0]  REVS_RST      = 8'd20;

  // arithmetic constants
  localparam logic [RPM_W-1:0] RPM_NUMERATOR = 16'd60000;
  localparam logic [RPM_W-1:0] RPM_SAT       = 16'hFFFF;

  // last step indices of the serial divider and multiplier
  localparam logic [3:0] DIV_LAST = 4'(RPM_W - 1);
  localparam logic [3:0] MUL_LAST = 4'(COUNT_W - 1);

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

endpackage

// ===== hdl/htr_if.sv =====
// ----------------------------------------------------------------------------
// htr_if: valid/ready channels of the hall tachometer
// Sample channel into the block and rpm result channel out of it.
// ----------------------------------------------------------------------------

// sample channel
interface htr_in_if;
  logic        valid;
  logic        ready;
  logic [9:0]  hall_sample;
  logic [31:0] time_ms;
  logic        clear_max;

  modport source (output valid, hall_sample, time_ms, clear_max, input ready);
  modport sink   (input valid, hall_sample, time_ms, clear_max, output ready);
endinterface

// rpm result channel
interface htr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] rpm_value;
  logic [15:0] rpm_peak;
  logic        rpm_updated;

  modport source (output valid, rpm_value, rpm_peak, rpm_updated, input ready);
  modport sink   (input valid, rpm_value, rpm_peak, rpm_updated, output ready);
endinterface

// ===== hdl/hall_tachometer_rpm.sv =====
// A sample that completes no update gives its result in the cycle after acceptance.
// An update runs the bit-serial divider (one quotient bit a cycle), then the shift-add
// multiplier (one count bit a cycle), then a finish step that waits for a free output;
// a zero or overlong window skips straight to the finish step. Throughput: one sample a
// cycle without updates while the output is free, none while an update runs. Reset
// (rst_n low, synchronous) clears the tachometer state and loads the register defaults.
// ----------------------------------------------------------------------------
// hall_tachometer_rpm: hall sensor tachometer
// Counts revolutions from hall samples and computes a saturated rpm with a
// running peak, using a serial divider and multiplier.
// ----------------------------------------------------------------------------
module hall_tachometer_rpm (
  input  logic                               clk,
  input  logic                               rst_n,
  htr_in_if.sink                             in_ch,
  htr_out_if.source                          out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [htr_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [htr_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [htr_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  // configuration registers
  logic [htr_pkg::SAMPLE_W-1:0] thr_r;
  logic [htr_pkg::COUNT_W-1:0]  revs_r;

  // tachometer state
  logic                         armed_r;
  logic [htr_pkg::COUNT_W-1:0]  cnt_r;
  logic [htr_pkg::TIME_W-1:0]   last_r;
  logic [htr_pkg::RPM_W-1:0]    rpm_r;
  logic [htr_pkg::RPM_W-1:0]    max_r;
  htr_pkg::state_t              state_r;
  logic [3:0]                   step_r;

  // serial arithmetic
  logic [htr_pkg::RPM_W-1:0]    div_r;
  logic [htr_pkg::RPM_W-1:0]    rem_r;
  logic [htr_pkg::RPM_W-1:0]    quo_r;
  logic [htr_pkg::COUNT_W-1:0]  mcnt_r;
  logic [htr_pkg::PROD_W-1:0]   acc_r;

  // output register
  logic                         out_valid_r;
  logic [htr_pkg::RPM_W-1:0]    out_value_r;
  logic [htr_pkg::RPM_W-1:0]    out_peak_r;
  logic                         out_upd_r;

  logic                         in_fire;
  logic                         out_free;
  logic                         out_load;
  logic                         cfg_wr;
  logic                         armed_nxt;
  logic [htr_pkg::COUNT_W-1:0]  cnt_nxt;
  logic                         upd_now;
  logic [htr_pkg::TIME_W-1:0]   elapsed;
  logic [htr_pkg::RPM_W-1:0]    max_clr;
  logic [htr_pkg::RPM_W:0]      trial;
  logic [htr_pkg::RPM_W:0]      diff;
  logic                         qbit;
  logic [htr_pkg::RPM_W-1:0]    rem_nxt;
  logic [htr_pkg::PROD_W-1:0]   acc_nxt;
  logic [htr_pkg::RPM_W-1:0]    rpm_fin;
  logic [htr_pkg::RPM_W-1:0]    peak_fin;

  // apb access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == htr_pkg::REG_REVS_PER_UPDATE)
                  ? {{(htr_pkg::CFG_DATA_W-htr_pkg::COUNT_W){1'b0}}, revs_r}
                  : {{(htr_pkg::CFG_DATA_W-htr_pkg::SAMPLE_W){1'b0}}, thr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= htr_pkg::THRESHOLD_RST;
      revs_r <= htr_pkg::REVS_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        htr_pkg::REG_ARM_THRESHOLD:   thr_r  <= pwdata[htr_pkg::SAMPLE_W-1:0];
        htr_pkg::REG_REVS_PER_UPDATE: revs_r <= pwdata[htr_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // handshakes
  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == htr_pkg::ST_IDLE) && out_free;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // pulse detection on the incoming sample
  always_comb begin
    armed_nxt = armed_r;
    cnt_nxt   = cnt_r;
    if (in_ch.hall_sample < thr_r) begin
      armed_nxt = 1'b1;
    end else if (in_ch.hall_sample > thr_r && armed_r) begin
      armed_nxt = 1'b0;
      cnt_nxt   = cnt_r + 8'd1;
    end
  end

  assign upd_now = cnt_nxt >= revs_r;
  assign elapsed = in_ch.time_ms - last_r;
  assign max_clr = in_ch.clear_max ? '0 : max_r;

  // result register reloads on a plain sample or a finished update
  assign out_load = ((state_r == htr_pkg::ST_IDLE) && in_fire && !upd_now)
                    || ((state_r == htr_pkg::ST_FIN) && out_free);

  // one restoring division step
  assign trial   = {rem_r, quo_r[htr_pkg::RPM_W-1]};
  assign diff    = trial - {1'b0, div_r};
  assign qbit    = trial >= {1'b0, div_r};
  assign rem_nxt = qbit ? diff[htr_pkg::RPM_W-1:0] : trial[htr_pkg::RPM_W-1:0];

  // one shift-add multiply step, count msb first
  assign acc_nxt = {acc_r[htr_pkg::PROD_W-2:0], 1'b0}
                   + (mcnt_r[htr_pkg::COUNT_W-1]
                      ? {{(htr_pkg::PROD_W-htr_pkg::RPM_W){1'b0}}, quo_r}
                      : '0);

  // saturation and peak at the end of an update
  assign rpm_fin  = (|acc_r[htr_pkg::PROD_W-1:htr_pkg::RPM_W])
                    ? htr_pkg::RPM_SAT : acc_r[htr_pkg::RPM_W-1:0];
  assign peak_fin = (rpm_fin > max_r) ? rpm_fin : max_r;

  // control and tachometer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r     <= 1'b0;
      cnt_r       <= '0;
      last_r      <= '0;
      rpm_r       <= '0;
      max_r       <= '0;
      state_r     <= htr_pkg::ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        htr_pkg::ST_IDLE: begin
          if (in_fire) begin
            armed_r <= armed_nxt;
            max_r   <= max_clr;
            step_r  <= '0;
            if (upd_now) begin
              cnt_r  <= '0;
              last_r <= in_ch.time_ms;
              if (elapsed == '0 || elapsed[htr_pkg::TIME_W-1:htr_pkg::RPM_W] != '0) begin
                state_r <= htr_pkg::ST_FIN;
              end else begin
                state_r <= htr_pkg::ST_DIV;
              end
            end else begin
              cnt_r <= cnt_nxt;
            end
          end
        end
        htr_pkg::ST_DIV: begin
          if (step_r == htr_pkg::DIV_LAST) begin
            step_r  <= '0;
            state_r <= htr_pkg::ST_MUL;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        htr_pkg::ST_MUL: begin
          if (step_r == htr_pkg::MUL_LAST) begin
            step_r  <= '0;
            state_r <= htr_pkg::ST_FIN;
          end else begin
            step_r <= step_r + 4'd1;
          end
        end
        htr_pkg::ST_FIN: begin
          if (out_free) begin
            rpm_r   <= rpm_fin;
            max_r   <= peak_fin;
            state_r <= htr_pkg::ST_IDLE;
          end
        end
        default: state_r <= htr_pkg::ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      htr_pkg::ST_IDLE: begin
        if (in_fire) begin
          div_r  <= elapsed[htr_pkg::RPM_W-1:0];
          rem_r  <= '0;
          quo_r  <= htr_pkg::RPM_NUMERATOR;
          mcnt_r <= cnt_nxt;
          if (elapsed == '0) begin
            acc_r <= {{(htr_pkg::PROD_W-htr_pkg::RPM_W){1'b0}}, htr_pkg::RPM_SAT};
          end else begin
            acc_r <= '0;
          end
          if (!upd_now) begin
            out_value_r <= rpm_r;
            out_peak_r  <= max_clr;
            out_upd_r   <= 1'b0;
          end
        end
      end
      htr_pkg::ST_DIV: begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[htr_pkg::RPM_W-2:0], qbit};
      end
      htr_pkg::ST_MUL: begin
        acc_r  <= acc_nxt;
        mcnt_r <= {mcnt_r[htr_pkg::COUNT_W-2:0], 1'b0};
      end
      htr_pkg::ST_FIN: begin
        if (out_free) begin
          out_value_r <= rpm_fin;
          out_peak_r  <= peak_fin;
          out_upd_r   <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // result channel
  assign out_ch.valid       = out_valid_r;
  assign out_ch.rpm_value   = out_value_r;
  assign out_ch.rpm_peak    = out_peak_r;
  assign out_ch.rpm_updated = out_upd_r;

  // checks
  a_peak_covers_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_upd_r |-> out_peak_r >= out_value_r)
    else $error("peak below freshly computed rpm");

  a_update_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && upd_now |=> state_r != htr_pkg::ST_IDLE && !out_valid_r)
    else $error("update transaction did not start the serial datapath");

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != htr_pkg::ST_IDLE |-> !in_ch.ready)
    else $error("sample accepted during rpm computation");

endmodule

// ===== tb/tb_hall_tachometer_rpm.sv =====
// ----------------------------------------------------------------------------
// tb_hall_tachometer_rpm: self-checking bench for the hall tachometer
// Streams hall samples with random handshake gaps into the block, predicts
// every rpm transaction in-bench and compares it field by field, over
// several threshold and revolution-target settings written through apb.
// ----------------------------------------------------------------------------
module tb_hall_tachometer_rpm;
  timeunit 1ns;
  timeprecision 1ps;

  // widths and constants taken from the package
  localparam int unsigned SAMPLE_W   = htr_pkg::SAMPLE_W;
  localparam int unsigned TIME_W     = htr_pkg::TIME_W;
  localparam int unsigned COUNT_W    = htr_pkg::COUNT_W;
  localparam int unsigned RPM_W      = htr_pkg::RPM_W;
  localparam int unsigned CFG_ADDR_W = htr_pkg::CFG_ADDR_W;
  localparam int unsigned CFG_DATA_W = htr_pkg::CFG_DATA_W;
  localparam logic        REG_ARM_THRESHOLD   = htr_pkg::REG_ARM_THRESHOLD;
  localparam logic        REG_REVS_PER_UPDATE = htr_pkg::REG_REVS_PER_UPDATE;
  localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = htr_pkg::THRESHOLD_RST;
  localparam logic [COUNT_W-1:0]  REVS_RST      = htr_pkg::REVS_RST;
  localparam logic [RPM_W-1:0]    RPM_NUMERATOR = htr_pkg::RPM_NUMERATOR;
  localparam logic [RPM_W-1:0]    RPM_SAT       = htr_pkg::RPM_SAT;

  localparam int unsigned CLK_PERIOD     = 20;
  localparam int unsigned TIMEOUT_CYCLES = 400_000;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned HOLD_AFTER     = 120;
  localparam int unsigned RAND_PHASES    = 5;
  localparam int unsigned PHASE_ITEMS    = 86;

  typedef struct packed {
    logic [SAMPLE_W-1:0] hall_sample;
    logic [TIME_W-1:0]   time_ms;
    logic                clear_max;
  } hall_item_t;

  typedef struct packed {
    logic [RPM_W-1:0] rpm_value;
    logic [RPM_W-1:0] rpm_peak;
    logic             rpm_updated;
  } rpm_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  htr_in_if  in_if();
  htr_out_if out_if();

  hall_tachometer_rpm dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // sample stream and expected rpm transactions
  hall_item_t  sample_q[$];
  rpm_result_t rpm_exp_q[$];
  hall_item_t  next_item;

  // in-bench tachometer state and register copies
  logic [SAMPLE_W-1:0] thr_q;
  logic [COUNT_W-1:0]  target_q;
  logic                armed_q   = 1'b0;
  logic [COUNT_W-1:0]  revs_seen = '0;
  logic [TIME_W-1:0]   mark_ms   = '0;
  logic [RPM_W-1:0]    rpm_now   = '0;
  logic [RPM_W-1:0]    rpm_top   = '0;

  // stimulus clock and bookkeeping
  logic [TIME_W-1:0] clock_ms;
  int  err_count      = 0;
  int  samples_taken  = 0;
  int  updates_seen   = 0;
  int  saturated_seen = 0;
  int  settings_used;
  int  src_gap;
  bit  src_burst  = 1'b0;
  int  sink_wait;
  int  stall;
  bit  sink_burst = 1'b0;
  logic hold_rx;

  // advance the tachometer by one sample and return the rpm transaction
  function automatic rpm_result_t tach_step(input logic [SAMPLE_W-1:0] hall,
                                            input logic [TIME_W-1:0] now,
                                            input logic clr);
    rpm_result_t res;
    logic [TIME_W-1:0] elapsed;
    logic [31:0]       quot;
    logic [63:0]       prod;
    res.rpm_updated = 1'b0;
    if (clr) rpm_top = '0;
    if (hall < thr_q) begin
      armed_q = 1'b1;
    end else if (hall > thr_q && armed_q) begin
      revs_seen = revs_seen + 8'd1;
      armed_q   = 1'b0;
    end
    // revolution target met: rpm over the elapsed window
    if (revs_seen >= target_q) begin
      elapsed = now - mark_ms;
      if (elapsed == '0) begin
        rpm_now = RPM_SAT;
      end else begin
        quot = 32'(RPM_NUMERATOR) / elapsed;
        prod = 64'(quot) * 64'(revs_seen);
        rpm_now = (prod > 64'(RPM_SAT)) ? RPM_SAT : prod[RPM_W-1:0];
      end
      mark_ms   = now;
      revs_seen = '0;
      if (rpm_now > rpm_top) rpm_top = rpm_now;
      res.rpm_updated = 1'b1;
    end
    res.rpm_value = rpm_now;
    res.rpm_peak  = rpm_top;
    return res;
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid       <= 1'b0;
      in_if.hall_sample <= '0;
      in_if.time_ms     <= '0;
      in_if.clear_max   <= 1'b0;
      src_gap           <= 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        rpm_exp_q.push_back(tach_step(in_if.hall_sample, in_if.time_ms, in_if.clear_max));
        samples_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (src_gap != 0) begin
          src_gap     <= src_gap - 1;
          in_if.valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          next_item = sample_q.pop_front();
          in_if.hall_sample <= next_item.hall_sample;
          in_if.time_ms     <= next_item.time_ms;
          in_if.clear_max   <= next_item.clear_max;
          in_if.valid       <= 1'b1;
          if ($urandom_range(0, 29) == 0) src_burst = !src_burst;
          src_gap <= src_burst ? 0 : $urandom_range(0, 15);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // rpm monitor and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      sink_wait    <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (out_if.rpm_updated) begin
          updates_seen++;
          if (out_if.rpm_value == RPM_SAT) saturated_seen++;
        end
        if (rpm_exp_q.size() == 0) begin
          $error("rpm transaction with no pending expectation");
          err_count++;
        end else begin
          if (out_if.rpm_value !== rpm_exp_q[0].rpm_value) begin
            $error("rpm_value expected %0d actual %0d", rpm_exp_q[0].rpm_value,
                   out_if.rpm_value);
            err_count++;
          end
          if (out_if.rpm_peak !== rpm_exp_q[0].rpm_peak) begin
            $error("rpm_peak expected %0d actual %0d", rpm_exp_q[0].rpm_peak,
                   out_if.rpm_peak);
            err_count++;
          end
          if (out_if.rpm_updated !== rpm_exp_q[0].rpm_updated) begin
            $error("rpm_updated expected %0d actual %0d", rpm_exp_q[0].rpm_updated,
                   out_if.rpm_updated);
            err_count++;
          end
          void'(rpm_exp_q.pop_front());
        end
      end
      // receiver stalls
      if (hold_rx) begin
        out_if.ready <= 1'b0;
      end else if (out_if.valid && out_if.ready) begin
        if ($urandom_range(0, 29) == 0) sink_burst = !sink_burst;
        stall = sink_burst ? 0 : $urandom_range(0, 15);
        sink_wait    <= stall;
        out_if.ready <= (stall == 0);
      end else if (sink_wait != 0) begin
        sink_wait    <= sink_wait - 1;
        out_if.ready <= (sink_wait == 1);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // long receiver hold-off so the block backs up and stalls its input
  initial begin
    hold_rx <= 1'b0;
    while (samples_taken < HOLD_AFTER) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // apb register write: setup then access phase
  task automatic reg_write(input logic idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ARM_THRESHOLD:   thr_q    = value[SAMPLE_W-1:0];
      REG_REVS_PER_UPDATE: target_q = value[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  // both registers, with junk above the field widths
  task automatic set_config(input logic [SAMPLE_W-1:0] thr, input logic [COUNT_W-1:0] target);
    reg_write(REG_ARM_THRESHOLD, {22'($urandom()), thr});
    reg_write(REG_REVS_PER_UPDATE, {24'($urandom()), target});
    settings_used++;
  endtask

  task automatic push_sample(input logic [SAMPLE_W-1:0] hall, input logic [TIME_W-1:0] t,
                             input logic clr);
    hall_item_t it;
    it.hall_sample = hall;
    it.time_ms     = t;
    it.clear_max   = clr;
    sample_q.push_back(it);
  endtask

  // wait until every queued sample is in and every rpm transaction is out
  task automatic drain_pipeline();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_if.valid || rpm_exp_q.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // mostly small steps, sometimes long gaps or a jump anywhere
  task automatic advance_clock();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) clock_ms = $urandom();
    else if (roll < 3) clock_ms = clock_ms + $urandom_range(0, 5000);
    else clock_ms = clock_ms + $urandom_range(0, 30);
  endtask

  // random phase: mostly arm/fire pulse pairs, plus equal-level and noise samples
  task automatic queue_random(input int count);
    int n;
    int roll;
    logic [SAMPLE_W-1:0] lo_lvl;
    logic [SAMPLE_W-1:0] hi_lvl;
    n = 0;
    while (n < count) begin
      roll = $urandom_range(0, 9);
      lo_lvl = (thr_q == '0) ? '0 : SAMPLE_W'($urandom_range(0, thr_q - 1));
      hi_lvl = (thr_q == '1) ? '1 : SAMPLE_W'($urandom_range(thr_q + 1, 1023));
      advance_clock();
      if (roll < 7) begin
        push_sample(lo_lvl, clock_ms, $urandom_range(0, 15) == 0);
        advance_clock();
        push_sample(hi_lvl, clock_ms, $urandom_range(0, 15) == 0);
        n += 2;
      end else if (roll == 7) begin
        push_sample(thr_q, clock_ms, $urandom_range(0, 7) == 0);
        n++;
      end else begin
        push_sample(SAMPLE_W'($urandom()), clock_ms, $urandom_range(0, 3) == 0);
        n++;
      end
    end
  endtask

  // main sequence
  initial begin
    rst_n   <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    thr_q     = THRESHOLD_RST;
    target_q  = REVS_RST;
    clock_ms  = '0;
    settings_used  = 1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: equal level, arm, count with clear, fire while disarmed
    push_sample(10'd430, 32'd0, 1'b0);
    push_sample(10'd0, 32'd1, 1'b0);
    push_sample(10'd1023, 32'd2, 1'b1);
    push_sample(10'd1023, 32'd3, 1'b0);
    drain_pipeline();

    // one revolution per update: zero elapsed, clear with update, time wrap
    set_config(10'd430, 8'd1);
    push_sample(10'd429, 32'd4, 1'b0);
    push_sample(10'd431, 32'd4, 1'b0);
    push_sample(10'd0, 32'd4, 1'b0);
    push_sample(10'd1023, 32'd4, 1'b0);
    push_sample(10'd0, 32'hFFFF_FFF0, 1'b0);
    push_sample(10'd1023, 32'hFFFF_FFF0, 1'b1);
    push_sample(10'd0, 32'h0000_0010, 1'b0);
    push_sample(10'd1023, 32'h0000_0010, 1'b0);
    drain_pipeline();

    // two revolutions in one ms: product saturates
    set_config(10'd430, 8'd2);
    push_sample(10'd0, 32'h0000_0010, 1'b0);
    push_sample(10'd1023, 32'h0000_0010, 1'b0);
    push_sample(10'd0, 32'h0000_0011, 1'b0);
    push_sample(10'd1023, 32'h0000_0011, 1'b0);
    drain_pipeline();

    // zero target: every sample updates
    set_config(10'd430, 8'd0);
    push_sample(10'd430, 32'h0000_0020, 1'b0);
    push_sample(10'd0, 32'h0000_0025, 1'b0);
    push_sample(10'd1023, 32'h0000_0030, 1'b0);
    drain_pipeline();

    // threshold extremes with the largest target
    set_config(10'd0, 8'd255);
    push_sample(10'd0, 32'h0000_0040, 1'b0);
    push_sample(10'd1023, 32'h0000_0041, 1'b0);
    push_sample(10'd1, 32'h0000_0042, 1'b1);
    drain_pipeline();
    set_config(10'd1023, 8'd255);
    push_sample(10'd1022, 32'h0000_0050, 1'b0);
    push_sample(10'd1023, 32'h0000_0051, 1'b0);
    drain_pipeline();

    // random phases over varied settings
    clock_ms = 32'hFFFF_F000;
    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: set_config(SAMPLE_W'($urandom_range(100, 900)), COUNT_W'($urandom_range(1, 4)));
        1: set_config(10'd1, 8'd1);
        2: set_config(10'd1022, 8'd2);
        3: set_config(SAMPLE_W'($urandom()), COUNT_W'($urandom_range(1, 8)));
        default: set_config(SAMPLE_W'($urandom_range(1, 1022)), 8'd0);
      endcase
      queue_random(PHASE_ITEMS);
      drain_pipeline();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (rpm_exp_q.size() != 0) begin
      $error("%0d rpm transactions never arrived", rpm_exp_q.size());
    end
    $display("covered %0d samples over %0d register settings", samples_taken, settings_used);
    $display("saw %0d rpm updates, %0d of them saturated", updates_seen, saturated_seen);
    if (err_count == 0 && rpm_exp_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("tb: failure");
    $finish;
  end

endmodule
